### rtl/sts_pkg.sv
package sts_pkg;

	localparam int ANGLE_W = 32;
	localparam int OUT_W   = 32;
	localparam int CNT_W   = 6;
	localparam int TOL_W   = 31;
	localparam int Y_W     = 33;
	localparam int Y2_W    = 36;
	localparam int MAG_W   = 40;
	localparam int PRD_W   = 46;
	localparam int SUM_W   = 48;
	localparam int U_W     = 34;
	localparam int Q_W     = 6;

	// operand halves for the split multiplies of each term
	localparam int MH_W    = MAG_W / 2;
	localparam int PH_W    = PRD_W / 2;
	localparam int RK_W    = 30;
	localparam int PP1_W   = MH_W + Y2_W;
	localparam int PP2_W   = PH_W + RK_W;

	// 2*pi in Q8.24, with pi taken as 3.141592
	localparam longint TWO_PI_Q24 = 64'd105414335;
	// bias that makes every legal angle non-negative before the wrap
	localparam longint WRAP_BIAS  = 64'd21 * TWO_PI_Q24;
	// ceil(2^40 / TWO_PI_Q24) for the quotient estimate
	localparam longint RECIP_M    = 64'd10431;
	localparam int     RECIP_SH   = 40;
	localparam logic [TOL_W-1:0] TOL_RESET = 31'd536871;

	typedef logic [MAG_W-1:0] mag_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	// state of one request as it walks the term stages
	typedef struct packed {
		logic             neg;
		mag_t             mag;
		sum_t             sum;
		logic [CNT_W-1:0] cnt;
		logic             done;
		logic             act;
		logic [Y2_W-1:0]  y2;
	} term_ctx_t;

endpackage

### rtl/sine_taylor_series_top.sv
// Sine of a Q8.24 angle by the Maclaurin series, returned in Q2.30 with the
// count of correction terms and a limit flag. The angle is wrapped into
// [0, 2*pi) and each series term has its own four pipeline stages (each of its
// two multiplies is split into partial products and a combining add), so a
// new request is taken every cycle while the output is not stalled. Any stall
// at the output holds the whole pipeline. Tolerance is written through
// cfg_we/cfg_data and is used by every term stage.
module sine_taylor_series_top #(
	parameter int MAX_TERMS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sts_pkg::TOL_W-1:0]       cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [31:0]                     s_axis_tdata,  // [31:0] angle
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [39:0]                     m_axis_tdata   // [31:0] sine_value,
	                                                       // [37:32] terms_used,
	                                                       // [38] hit_limit, [39] 0
);
	import sts_pkg::*;

	localparam int N = MAX_TERMS;

	logic [TOL_W-1:0] tol_q;
	logic             en;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_data;
		end
	end

	// wrap stages
	logic           v_s1, v_s2, v_s3, v_s4;
	logic [U_W-1:0] u_s1, u_s2;
	logic [Q_W-1:0] q_s2;
	logic [Y_W-1:0] y_s3;
	logic [Y_W-1:0] y_s4;
	logic [Y2_W-1:0] y2_s4;

	logic [U_W+14-1:0]      q_prod;
	logic signed [U_W:0]    r_raw;
	logic signed [U_W:0]    r_fix;
	logic [2*Y_W-1:0]       yy;

	assign q_prod = u_s1 * RECIP_M[13:0];
	assign r_raw  = $signed({1'b0, u_s2})
		- $signed({1'b0, U_W'(U_W'(q_s2) * U_W'(TWO_PI_Q24[26:0]))});
	assign r_fix  = (r_raw < 0) ? r_raw + $signed((U_W+1)'(TWO_PI_Q24)) : r_raw;
	assign yy     = y_s3 * y_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1  <= U_W'($signed({{(U_W-ANGLE_W){s_axis_tdata[31]}}, s_axis_tdata})
				+ $signed(U_W'(WRAP_BIAS)));
			u_s2  <= u_s1;
			q_s2  <= Q_W'(q_prod >> RECIP_SH);
			y_s3  <= Y_W'({r_fix[26:0], 6'b0});
			y_s4  <= y_s3;
			y2_s4 <= Y2_W'(yy >> 30);
		end
	end

	// term pipeline: index 0 is the first term (y), stage k forms term k
	logic             tv_s [N+1];
	term_ctx_t        t_s  [N+1];

	logic             v1_s  [1:N];
	term_ctx_t        c1_s  [1:N];
	logic [PP1_W-1:0] pl1_s [1:N];
	logic [PP1_W-1:0] ph1_s [1:N];
	logic             v2_s  [1:N];
	term_ctx_t        c2_s  [1:N];
	logic [PRD_W-1:0] p2_s  [1:N];
	logic             v3_s  [1:N];
	term_ctx_t        c3_s  [1:N];
	logic [PP2_W-1:0] ml3_s [1:N];
	logic [PP2_W-1:0] mh3_s [1:N];

	always_comb begin
		tv_s[0]    = v_s4;
		t_s[0]     = '0;
		t_s[0].mag = MAG_W'(y_s4);
		t_s[0].sum = SUM_W'($signed({1'b0, y_s4}));
		t_s[0].y2  = y2_s4;
	end

	for (genvar k = 1; k <= N; k++) begin : g_term
		localparam longint D  = 64'(2 * k) * 64'(2 * k + 1);
		localparam longint RK = (64'd1073741824 + D / 2) / D;

		logic [PP1_W+MH_W-1:0] p_full;
		logic [PP2_W+PH_W-1:0] m_full;
		mag_t                  m_new;
		term_ctx_t             ctx_in;
		term_ctx_t             ctx_nxt;

		always_comb begin
			ctx_in     = t_s[k-1];
			ctx_in.act = !t_s[k-1].done && (t_s[k-1].mag > MAG_W'(tol_q));
		end

		assign p_full = {ph1_s[k], {MH_W{1'b0}}} + (PP1_W+MH_W)'(pl1_s[k]);
		assign m_full = {mh3_s[k], {PH_W{1'b0}}} + (PP2_W+PH_W)'(ml3_s[k]);
		assign m_new  = MAG_W'(m_full >> 30);

		always_comb begin
			ctx_nxt = c3_s[k];
			if (c3_s[k].act) begin
				// next term flips sign
				ctx_nxt.neg = !c3_s[k].neg;
				ctx_nxt.mag = m_new;
				ctx_nxt.sum = c3_s[k].neg ? c3_s[k].sum + SUM_W'(m_new)
					: c3_s[k].sum - SUM_W'(m_new);
				ctx_nxt.cnt = c3_s[k].cnt + CNT_W'(1);
			end else begin
				ctx_nxt.done = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v1_s[k] <= 1'b0;
				v2_s[k] <= 1'b0;
				v3_s[k] <= 1'b0;
				tv_s[k] <= 1'b0;
			end else if (en) begin
				v1_s[k] <= tv_s[k-1];
				v2_s[k] <= v1_s[k];
				v3_s[k] <= v2_s[k];
				tv_s[k] <= v3_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				c1_s[k]  <= ctx_in;
				pl1_s[k] <= t_s[k-1].mag[MH_W-1:0] * t_s[k-1].y2;
				ph1_s[k] <= t_s[k-1].mag[MAG_W-1:MH_W] * t_s[k-1].y2;
				c2_s[k]  <= c1_s[k];
				p2_s[k]  <= PRD_W'(p_full >> 30);
				c3_s[k]  <= c2_s[k];
				ml3_s[k] <= p2_s[k][PH_W-1:0] * RK[RK_W-1:0];
				mh3_s[k] <= p2_s[k][PRD_W-1:PH_W] * RK[RK_W-1:0];
				t_s[k]   <= ctx_nxt;
			end
		end
	end

	// output register with saturation
	logic [OUT_W-1:0] sine_q;
	logic [CNT_W-1:0] cnt_q;
	logic             lim_q;
	logic [OUT_W-1:0] sat;
	sum_t             fin_sum;

	assign fin_sum = t_s[N].sum;

	always_comb begin
		if (fin_sum > $signed(SUM_W'(64'h7FFFFFFF))) begin
			sat = 32'h7FFFFFFF;
		end else if (fin_sum < -$signed(SUM_W'(64'h80000000))) begin
			sat = 32'h80000000;
		end else begin
			sat = fin_sum[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= tv_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sine_q <= sat;
			cnt_q  <= t_s[N].cnt;
			lim_q  <= t_s[N].mag > MAG_W'(tol_q);
		end
	end

	assign m_axis_tdata = {1'b0, lim_q, cnt_q, sine_q};

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (cnt_q <= CNT_W'(N)))
		else $error("terms_used above MAX_TERMS");

	a_lim_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && lim_q) |-> (cnt_q == CNT_W'(N)))
		else $error("limit flag without all terms");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result changed under stall");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output stall");

endmodule

### tb/tb_sine_taylor_series_top.sv
`timescale 1ns / 1ps

module tb_sine_taylor_series_top;
	import sts_pkg::*;

	localparam int MAX_TERMS = 16;
	localparam int PIPE_LAT  = 4 * MAX_TERMS + 5;

	typedef struct {
		logic signed [OUT_W-1:0] sine_value;
		logic [CNT_W-1:0]        terms_used;
		logic                    hit_limit;
	} sine_res_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [TOL_W-1:0]  cfg_data = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [31:0]       s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [39:0]       m_axis_tdata;

	logic [31:0]       angle_queue[$];
	sine_res_t         sine_expected[$];
	logic [TOL_W-1:0]  tol_model = TOL_RESET;
	int                err_count = 0;
	int                sent_count = 0;
	int                got_count = 0;
	int                queued_count = 0;
	int                limit_count = 0;
	bit                tx_gaps = 1'b1;
	bit                rx_gaps = 1'b1;
	int                rx_hold_req = 0;

	logic [31:0]       corner_angles[16] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
		32'hFFFF_FFFF, 32'd105414335, 32'd105414334, -32'sd105414335,
		32'd105414336, 32'd26353584, 32'd52707168, 32'd79060752, 32'd300,
		-32'sd300, 32'h5555_5555, 32'hAAAA_AAAA};

	sine_taylor_series_top #(.MAX_TERMS(MAX_TERMS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// signed Q30 product, formed as sign and magnitude, truncated toward zero
	function automatic longint q30_mul(longint a, longint b);
		logic [63:0]  ma, mb, res;
		logic [127:0] prod;
		bit           neg;
		neg = (a < 0) != (b < 0);
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		prod = ma * mb;
		if (prod[127:93] != 0)
			res = 64'd1 << 62;
		else
			res = prod[93:30];
		if (res > (64'd1 << 62))
			res = 64'd1 << 62;
		return neg ? -longint'(res) : longint'(res);
	endfunction

	function automatic longint inv_pair(int unsigned k);
		longint d;
		d = (2 * longint'(k)) * (2 * longint'(k) + 1);
		return ((longint'(1) << 30) + d / 2) / d;
	endfunction

	function automatic longint abs64(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic sine_res_t predict_sine(logic [31:0] angle, logic [TOL_W-1:0] tol);
		longint    r, y, y2, term, sum;
		int        cnt;
		sine_res_t res;
		r = longint'($signed(angle)) % TWO_PI_Q24;
		if (r < 0)
			r += TWO_PI_Q24;
		y = r * 64;
		y2 = q30_mul(y, y);
		term = y;
		sum = y;
		cnt = 0;
		while (cnt < MAX_TERMS && abs64(term) > longint'(tol)) begin
			cnt++;
			term = -q30_mul(q30_mul(term, y2), inv_pair(cnt));
			sum += term;
		end
		res.hit_limit = abs64(term) > longint'(tol);
		if (sum > 64'sd2147483647)
			sum = 64'sd2147483647;
		if (sum < -64'sd2147483648)
			sum = -64'sd2147483648;
		res.sine_value = sum[31:0];
		res.terms_used = cnt[CNT_W-1:0];
		return res;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(0, 2);
	endfunction

	// request side
	int tx_gap = 0;
	always @(posedge clk) begin
		logic v;
		logic [31:0] d;
		v = s_axis_tvalid;
		d = s_axis_tdata;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				sine_expected.push_back(predict_sine(s_axis_tdata, tol_model));
				sent_count++;
				v = 1'b0;
			end
			if (!v) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (angle_queue.size() != 0) begin
					d = angle_queue.pop_front();
					v = 1'b1;
					tx_gap = tx_gaps ? pick_gap() : 0;
				end
			end
		end
		s_axis_tvalid <= v;
		s_axis_tdata <= d;
	end

	// result side
	int rx_gap = 0;
	int rx_hold = 0;
	always @(posedge clk) begin
		sine_res_t want;
		logic rdy;
		rdy = 1'b1;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_count++;
				if (sine_expected.size() == 0) begin
					$error("result with nothing expected: tdata=%h", m_axis_tdata);
					err_count++;
				end else begin
					want = sine_expected.pop_front();
					if (want.hit_limit)
						limit_count++;
					if (m_axis_tdata[31:0] !== want.sine_value) begin
						$error("sine_value: expected %0d, got %0d", want.sine_value,
							$signed(m_axis_tdata[31:0]));
						err_count++;
					end
					if (m_axis_tdata[37:32] !== want.terms_used) begin
						$error("terms_used: expected %0d, got %0d", want.terms_used,
							m_axis_tdata[37:32]);
						err_count++;
					end
					if (m_axis_tdata[38] !== want.hit_limit) begin
						$error("hit_limit: expected %0d, got %0d", want.hit_limit,
							m_axis_tdata[38]);
						err_count++;
					end
				end
			end
			if (rx_hold_req > 0 && rx_hold == 0) begin
				rx_hold = rx_hold_req;
				rx_hold_req = 0;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				rdy = 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				rdy = 1'b0;
			end else if (rx_gaps) begin
				rx_gap = pick_gap();
			end
		end
		m_axis_tready <= rdy;
	end

	task automatic wait_drained();
		while (got_count != queued_count)
			@(posedge clk);
		repeat (PIPE_LAT + 8) @(posedge clk);
	endtask

	task automatic write_tol(logic [TOL_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		tol_model = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_random(int n);
		longint span;
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: angle_queue.push_back($urandom());
				1: begin
					span = 4 * TWO_PI_Q24;
					angle_queue.push_back(32'($urandom_range(0, 2 * span) - span));
				end
				2: angle_queue.push_back(32'($urandom_range(0, 1 << 22)) - 32'd2097152);
				default: angle_queue.push_back(32'($urandom_range(0, TWO_PI_Q24 - 1)));
			endcase
			queued_count++;
		end
	endtask

	logic [TOL_W-1:0] tol_set[$];

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes at the reset tolerance
		foreach (corner_angles[i]) begin
			angle_queue.push_back(corner_angles[i]);
			queued_count++;
		end
		wait_drained();

		tol_set = '{TOL_RESET, 31'd0, 31'h7FFF_FFFF, 31'd1073741824, 31'd1,
			31'($urandom_range(1, 1 << 20)), 31'($urandom_range(1 << 20, 1 << 28)),
			TOL_RESET};
		foreach (tol_set[p]) begin
			write_tol(tol_set[p]);
			tx_gaps = (p != 2);
			rx_gaps = (p != 3);
			queue_random(p == 0 ? 400 : 160);
			// backpressure: hold tready low so that the stall freezes the whole pipeline
			if (p == 1 || p == 5)
				rx_hold_req = 200;
			wait_drained();
		end

		$display("Sent %0d angles over %0d tolerance settings;", sent_count,
			tol_set.size() + 1);
		$display("%0d results checked, %0d hit the term limit.", got_count, limit_count);
		if (err_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
